>>> sv/i2cep_pkg.sv
// ----------------------------------------------------------------------------
// i2cep_pkg
// Types, codes and reset values shared by the EEPROM page controller files.
// ----------------------------------------------------------------------------
package i2cep_pkg;

  // Bus sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_WSTART = 4'd1,
    ST_WSEL   = 4'd2,
    ST_AHI    = 4'd3,
    ST_ALO    = 4'd4,
    ST_DATA   = 4'd5,
    ST_RSTART = 4'd6,
    ST_RSEL   = 4'd7,
    ST_RECV   = 4'd8,
    ST_STOP   = 4'd9
  } ctl_state_e;

  // Request kind carried with each tick
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  // Transfer result codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BUSY     = 3'd1;
  localparam logic [2:0] ERR_ADDR_HI  = 3'd2;
  localparam logic [2:0] ERR_ADDR_LO  = 3'd3;
  localparam logic [2:0] ERR_DATA     = 3'd4;
  localparam logic [2:0] ERR_READ_SEL = 3'd5;

  // Configuration register indexes
  localparam logic CFG_POLL_LIMIT = 1'b0;
  localparam logic CFG_DEV_SEL    = 1'b1;

  localparam logic [15:0] POLL_LIMIT_RST = 16'd20000;
  localparam logic [6:0]  DEV_SEL_RST    = 7'd80;

  // Bit timing phases
  localparam logic [1:0] PH_SCL_LOW  = 2'd0;
  localparam logic [1:0] PH_SDA_SET  = 2'd1;
  localparam logic [1:0] PH_SCL_HIGH = 2'd2;

  localparam logic [3:0] ACK_BIT = 4'd8;

  // Sequencer state except the memory address
  typedef struct packed {
    ctl_state_e  st;
    logic [1:0]  phase;
    logic [3:0]  bit_idx;
    logic [7:0]  shift_byte;
    logic [15:0] bytes_left;
    logic [15:0] poll_count;
    logic        is_read;
    logic [2:0]  last_error;
    logic        scl;
    logic        sda;
    logic        ack_seen;
  } ctl_t;

  // One result word
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       byte_request;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [2:0] error_code;
  } res_t;

endpackage

>>> sv/i2cep_cfg.sv
// ----------------------------------------------------------------------------
// i2cep_cfg
// Configuration registers: poll limit and seven-bit device address.
// ----------------------------------------------------------------------------
module i2cep_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic [15:0] poll_limit_o,
  output logic [6:0]  dev_sel_o
);

  logic [15:0] poll_limit_q;
  logic [6:0]  dev_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= i2cep_pkg::POLL_LIMIT_RST;
      dev_sel_q    <= i2cep_pkg::DEV_SEL_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == i2cep_pkg::CFG_POLL_LIMIT) begin
        poll_limit_q <= cfg_data_i;
      end else begin
        dev_sel_q <= cfg_data_i[6:0];
      end
    end
  end

  assign poll_limit_o = poll_limit_q;
  assign dev_sel_o    = dev_sel_q;

endmodule

>>> sv/i2cep_step.sv
// ----------------------------------------------------------------------------
// i2cep_step
// Next-state logic for one quarter-bit tick of the I2C sequencer.
// ----------------------------------------------------------------------------
module i2cep_step #(
  parameter int PAGE_BYTES   = 64,  // power of two
  parameter int ADDRESS_BITS = 15
) (
  input  logic [1:0]              mode_i,
  input  logic [14:0]             start_address_i,
  input  logic [15:0]             length_i,
  input  logic [7:0]              write_data_i,
  input  logic                    sda_in_i,
  input  logic [15:0]             poll_limit_i,
  input  logic [6:0]              dev_sel_i,
  input  i2cep_pkg::ctl_t         ctl_i,
  input  logic [ADDRESS_BITS-1:0] addr_i,
  output i2cep_pkg::ctl_t         ctl_o,
  output logic [ADDRESS_BITS-1:0] addr_o,
  output i2cep_pkg::res_t         res_o
);

  localparam int PAGE_BITS = $clog2(PAGE_BYTES);

  i2cep_pkg::ctl_t         n;
  logic [ADDRESS_BITS-1:0] addr_n;
  logic [ADDRESS_BITS-1:0] addr_inc;
  logic [15:0]             addr_ext;
  logic [15:0]             inc_ext;
  logic [15:0]             left_dec;
  logic [15:0]             poll_inc;
  logic [7:0]              tx_byte;
  logic [1:0]              ph;
  i2cep_pkg::ctl_state_e   cs;
  logic                    req;
  logic                    rv;
  logic [7:0]              rb;
  logic                    done;

  always_comb begin
    n        = ctl_i;
    addr_n   = addr_i;
    req      = 1'b0;
    rv       = 1'b0;
    rb       = 8'd0;
    done     = 1'b0;
    addr_ext = 16'd0;
    addr_inc = '0;
    inc_ext  = 16'd0;
    left_dec = 16'd0;
    poll_inc = 16'd0;
    tx_byte  = 8'd0;
    ph       = 2'd0;
    cs       = i2cep_pkg::ST_IDLE;

    // Begin a transfer
    if (ctl_i.st == i2cep_pkg::ST_IDLE &&
        (mode_i == i2cep_pkg::MODE_WRITE || mode_i == i2cep_pkg::MODE_READ)) begin
      n.last_error = i2cep_pkg::ERR_NONE;
      if (length_i == 16'd0) begin
        done = 1'b1;
      end else begin
        addr_n       = ADDRESS_BITS'({1'b0, start_address_i});
        n.bytes_left = length_i;
        n.is_read    = (mode_i == i2cep_pkg::MODE_READ);
        n.poll_count = 16'd0;
        n.phase      = 2'd0;
        n.st         = i2cep_pkg::ST_WSTART;
        n.bit_idx    = 4'd0;
      end
    end

    if (n.st != i2cep_pkg::ST_IDLE) begin
      cs       = n.st;
      ph       = n.phase;
      n.phase  = n.phase + 2'd1;
      addr_ext = 16'(addr_n);
      addr_inc = addr_n + ADDRESS_BITS'(1);
      inc_ext  = 16'(addr_inc);
      left_dec = n.bytes_left - 16'd1;
      poll_inc = n.poll_count + 16'd1;

      case (cs)
        i2cep_pkg::ST_WSTART, i2cep_pkg::ST_RSTART, i2cep_pkg::ST_STOP: begin
          if (ph == i2cep_pkg::PH_SCL_LOW) begin
            n.scl = 1'b0;
          end else if (ph == i2cep_pkg::PH_SDA_SET) begin
            n.sda = (cs != i2cep_pkg::ST_STOP);
          end else if (ph == i2cep_pkg::PH_SCL_HIGH) begin
            n.scl = 1'b1;
          end else begin
            n.sda     = (cs == i2cep_pkg::ST_STOP);
            n.bit_idx = 4'd0;
            if (cs == i2cep_pkg::ST_WSTART) begin
              n.st = i2cep_pkg::ST_WSEL;
            end else if (cs == i2cep_pkg::ST_RSTART) begin
              n.st = i2cep_pkg::ST_RSEL;
            end else if (n.last_error != i2cep_pkg::ERR_NONE || n.bytes_left == 16'd0) begin
              n.st = i2cep_pkg::ST_IDLE;
              done = 1'b1;
            end else begin
              n.poll_count = 16'd0;
              n.st         = i2cep_pkg::ST_WSTART;
            end
          end
        end

        i2cep_pkg::ST_RECV: begin
          if (ph == i2cep_pkg::PH_SCL_LOW) begin
            n.scl = 1'b0;
            if (n.bit_idx == 4'd0) begin
              n.shift_byte = 8'd0;
            end
          end else if (ph == i2cep_pkg::PH_SDA_SET) begin
            // NACK only after the final byte
            n.sda = (n.bit_idx < i2cep_pkg::ACK_BIT) ? 1'b1 : (n.bytes_left <= 16'd1);
          end else if (ph == i2cep_pkg::PH_SCL_HIGH) begin
            n.scl = 1'b1;
            if (n.bit_idx < i2cep_pkg::ACK_BIT) begin
              n.shift_byte = {n.shift_byte[6:0], sda_in_i};
            end
          end else if (n.bit_idx < i2cep_pkg::ACK_BIT) begin
            n.bit_idx = n.bit_idx + 4'd1;
          end else begin
            rv           = 1'b1;
            rb           = n.shift_byte;
            addr_n       = addr_inc;
            n.bytes_left = left_dec;
            n.bit_idx    = 4'd0;
            n.st         = (left_dec == 16'd0) ? i2cep_pkg::ST_STOP : i2cep_pkg::ST_RECV;
          end
        end

        default: begin
          // Byte senders: select, address high, address low, data, read select
          case (cs)
            i2cep_pkg::ST_WSEL: tx_byte = {dev_sel_i, 1'b0};
            i2cep_pkg::ST_AHI:  tx_byte = addr_ext[15:8];
            i2cep_pkg::ST_ALO:  tx_byte = addr_ext[7:0];
            i2cep_pkg::ST_DATA: tx_byte = write_data_i;
            default:            tx_byte = {dev_sel_i, 1'b1};
          endcase

          if (ph == i2cep_pkg::PH_SCL_LOW) begin
            n.scl = 1'b0;
            if (n.bit_idx == 4'd0) begin
              n.shift_byte = tx_byte;
            end
          end else if (ph == i2cep_pkg::PH_SDA_SET) begin
            n.sda = (n.bit_idx < i2cep_pkg::ACK_BIT) ?
                    n.shift_byte[3'(3'd7 - n.bit_idx[2:0])] : 1'b1;
          end else if (ph == i2cep_pkg::PH_SCL_HIGH) begin
            n.scl = 1'b1;
            if (n.bit_idx >= i2cep_pkg::ACK_BIT) begin
              n.ack_seen = sda_in_i;
            end
          end else if (n.bit_idx < i2cep_pkg::ACK_BIT) begin
            n.bit_idx = n.bit_idx + 4'd1;
          end else begin
            n.bit_idx = 4'd0;
            case (cs)
              i2cep_pkg::ST_WSEL: begin
                if (!n.ack_seen) begin
                  n.st = i2cep_pkg::ST_AHI;
                end else begin
                  n.poll_count = poll_inc;
                  if (poll_inc >= poll_limit_i) begin
                    n.last_error = i2cep_pkg::ERR_BUSY;
                    n.st         = i2cep_pkg::ST_STOP;
                  end else begin
                    n.st = i2cep_pkg::ST_WSTART;
                  end
                end
              end
              i2cep_pkg::ST_AHI: begin
                if (n.ack_seen) begin
                  n.last_error = i2cep_pkg::ERR_ADDR_HI;
                  n.st         = i2cep_pkg::ST_STOP;
                end else begin
                  n.st = i2cep_pkg::ST_ALO;
                end
              end
              i2cep_pkg::ST_ALO: begin
                if (n.ack_seen) begin
                  n.last_error = i2cep_pkg::ERR_ADDR_LO;
                  n.st         = i2cep_pkg::ST_STOP;
                end else if (n.is_read) begin
                  n.st = i2cep_pkg::ST_RSTART;
                end else begin
                  n.st = i2cep_pkg::ST_DATA;
                  req  = 1'b1;
                end
              end
              i2cep_pkg::ST_DATA: begin
                if (n.ack_seen) begin
                  n.last_error = i2cep_pkg::ERR_DATA;
                  n.st         = i2cep_pkg::ST_STOP;
                end else begin
                  addr_n       = addr_inc;
                  n.bytes_left = left_dec;
                  // Close the page on the last byte or at a page boundary
                  if (left_dec == 16'd0 || inc_ext[PAGE_BITS-1:0] == '0) begin
                    n.st = i2cep_pkg::ST_STOP;
                  end else begin
                    n.st = i2cep_pkg::ST_DATA;
                    req  = 1'b1;
                  end
                end
              end
              default: begin
                if (n.ack_seen) begin
                  n.last_error = i2cep_pkg::ERR_READ_SEL;
                  n.st         = i2cep_pkg::ST_STOP;
                end else begin
                  n.st = i2cep_pkg::ST_RECV;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  assign ctl_o  = n;
  assign addr_o = addr_n;

  always_comb begin
    res_o.scl_level    = n.scl;
    res_o.sda_level    = n.sda;
    res_o.byte_request = req;
    res_o.read_byte    = rb;
    res_o.read_valid   = rv;
    res_o.busy_res     = (n.st != i2cep_pkg::ST_IDLE);
    res_o.done_res     = done;
    res_o.error_code   = n.last_error;
  end

endmodule

>>> sv/i2c_eeprom_page_controller_unit.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_page_controller_unit
// I2C master for a 32 KB serial EEPROM with page-split writes and reads.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on the s_axis channel is one quarter-bit tick of the I2C
//   bus; a clock divider upstream paces the words. tuser carries the mode:
//   plain tick, begin write or begin read. A begin word also carries the
//   start address and byte count; the word after a byte_request carries the
//   data byte to send. sda_in is the sampled data line on every word.
//   Each input word yields exactly one m_axis word with the line levels,
//   request/receive flags, busy and error code; tlast marks the word on
//   which a transfer ends.
//   Writes are split at PAGE_BYTES page boundaries, each page polled with
//   the write-select byte until acknowledged or the poll limit runs out.
//   The cfg channel writes the poll limit (index 0) and the device address
//   (index 1); write it only while no transfer is running.
// Throughput: an accepted input word is held in the input register, then
//   passes once through the tick logic into the output register; one word
//   per cycle sustained while m_axis_tready_i stays high.
// Reset: sequencer idle, both lines released high, registers at defaults.
// Stall: while m_axis_tready_i is low the result holds, one more input word
//   parks in the input register, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module i2c_eeprom_page_controller_unit #(
  parameter int PAGE_BYTES   = 64,  // power of two
  parameter int ADDRESS_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: start_address[14:0], length[30:15], write_data[38:31], sda_in[39]
  input  logic [39:0] s_axis_tdata_i,
  // tuser: mode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: scl_level[0], sda_level[1], byte_request[2], read_byte[10:3],
  //        read_valid[11], busy_res[12], error_code[15:13]
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,  // done_res
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic                    in_valid_q;
  logic [39:0]             in_data_q;
  logic [1:0]              in_user_q;
  logic                    out_valid_q;
  i2cep_pkg::res_t         res_q;
  i2cep_pkg::res_t         res_d;
  i2cep_pkg::ctl_t         ctl_q;
  i2cep_pkg::ctl_t         ctl_d;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [ADDRESS_BITS-1:0] addr_d;
  logic [15:0]             poll_limit;
  logic [6:0]              dev_sel;
  logic                    advance;

  // Advance the tick when a word waits and the output slot frees up
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  i2cep_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .poll_limit_o (poll_limit),
    .dev_sel_o    (dev_sel)
  );

  i2cep_step #(
    .PAGE_BYTES   (PAGE_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_step (
    .mode_i          (in_user_q),
    .start_address_i (in_data_q[14:0]),
    .length_i        (in_data_q[30:15]),
    .write_data_i    (in_data_q[38:31]),
    .sda_in_i        (in_data_q[39]),
    .poll_limit_i    (poll_limit),
    .dev_sel_i       (dev_sel),
    .ctl_i           (ctl_q),
    .addr_i          (addr_q),
    .ctl_o           (ctl_d),
    .addr_o          (addr_d),
    .res_o           (res_d)
  );

  // Input register: hold the word until the tick logic takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
  end

  // Sequencer state: update once per consumed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.st         <= i2cep_pkg::ST_IDLE;
      ctl_q.phase      <= 2'd0;
      ctl_q.bit_idx    <= 4'd0;
      ctl_q.shift_byte <= 8'd0;
      ctl_q.bytes_left <= 16'd0;
      ctl_q.poll_count <= 16'd0;
      ctl_q.is_read    <= 1'b0;
      ctl_q.last_error <= i2cep_pkg::ERR_NONE;
      ctl_q.scl        <= 1'b1;
      ctl_q.sda        <= 1'b1;
      ctl_q.ack_seen   <= 1'b0;
      addr_q           <= '0;
    end else if (advance) begin
      ctl_q  <= ctl_d;
      addr_q <= addr_d;
    end
  end

  // Output register: drop valid once taken unless a new result lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = res_q.done_res;
  assign m_axis_tdata_o  = {res_q.error_code, res_q.busy_res, res_q.read_valid,
                            res_q.read_byte, res_q.byte_request, res_q.sda_level,
                            res_q.scl_level};

endmodule

>>> dv/i2c_eeprom_page_controller_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_eeprom_page_controller_unit_tb
// Self-checking bench for the EEPROM page controller. An in-bench model of
// the bus master predicts every output word. An EEPROM responder picks the
// sampled data line level for each tick, so that it can acknowledge, refuse
// or return read data.
// ----------------------------------------------------------------------------
module i2c_eeprom_page_controller_unit_tb;
  import i2cep_pkg::*;

  localparam int PAGE_BYTES      = 64;
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no word moving
  localparam int HOLD_OFF_CYCLES = 600;   // long receiver stall
  localparam int PHASE_WORDS     = 120;   // random words per traffic phase

  // --------------------------------------------------------------------------
  // Bench signals: every block input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic [39:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = MODE_TICK;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_POLL_LIMIT;
  logic [15:0] cfg_data  = '0;

  i2c_eeprom_page_controller_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bus master model state and its copy of the registers
  // --------------------------------------------------------------------------
  ctl_state_e  pr_state;
  logic [1:0]  pr_phase;
  logic [3:0]  pr_bit;
  logic [7:0]  pr_shift;
  logic [14:0] pr_addr;
  logic [15:0] pr_left;
  logic [15:0] pr_polls;
  logic        pr_is_read;
  logic [2:0]  pr_err;
  logic        pr_scl;
  logic        pr_sda;
  logic        pr_ack;
  logic [15:0] cfg_poll_limit;
  logic [6:0]  cfg_dev_sel;

  // Output words still owed by the block, oldest first
  res_t expected_words[$];

  // Traffic knobs
  int         tx_gap_pct    = 0;   // sender idles this share of cycles
  int         rx_stall_pct  = 0;   // receiver stalls this share of cycles
  int         wsel_nack_pct = 0;   // device still busy with a page write
  int         noise_pct     = 0;   // stray refusals on other acknowledges
  ctl_state_e fault_state   = ST_IDLE;  // always refuse in this state
  int         hold_off_left = 0;

  int words_sent     = 0;
  int words_checked  = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;

  // --------------------------------------------------------------------------
  // Clock: 12 ns period
  // --------------------------------------------------------------------------
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------
  function automatic void enter_state(ctl_state_e st);
    pr_state = st;
    pr_bit   = '0;
  endfunction

  // Missing acknowledge: record the code and close with STOP
  function automatic void abort_transfer(logic [2:0] code);
    pr_err = code;
    enter_state(ST_STOP);
  endfunction

  // Advance the model by one accepted word and return the word it must emit
  task automatic step_bus_master(input mode_e m, input logic [14:0] a,
                                 input logic [15:0] len, input logic [7:0] wd,
                                 input logic sda_in, output res_t r);
    logic [1:0] ph;
    logic       req;
    logic       rv;
    logic       done;
    logic [7:0] rb;
    req  = 1'b0;
    rv   = 1'b0;
    done = 1'b0;
    rb   = '0;
    // A begin only counts while idle; a zero length ends on the spot
    if (pr_state == ST_IDLE && (m == MODE_WRITE || m == MODE_READ)) begin
      pr_err = ERR_NONE;
      if (len == 16'd0) begin
        done = 1'b1;
      end else begin
        pr_addr    = a;
        pr_left    = len;
        pr_is_read = (m == MODE_READ);
        pr_polls   = '0;
        pr_phase   = '0;
        enter_state(ST_WSTART);
      end
    end
    if (pr_state != ST_IDLE) begin
      ph       = pr_phase;
      pr_phase = pr_phase + 2'd1;
      case (pr_state)
        ST_WSTART, ST_RSTART, ST_STOP: begin
          if (ph == PH_SCL_LOW) begin
            pr_scl = 1'b0;
          end else if (ph == PH_SDA_SET) begin
            pr_sda = (pr_state != ST_STOP);
          end else if (ph == PH_SCL_HIGH) begin
            pr_scl = 1'b1;
          end else begin
            pr_sda = (pr_state == ST_STOP);
            if (pr_state == ST_WSTART) begin
              enter_state(ST_WSEL);
            end else if (pr_state == ST_RSTART) begin
              enter_state(ST_RSEL);
            end else if (pr_err != ERR_NONE || pr_left == 16'd0) begin
              enter_state(ST_IDLE);
              done = 1'b1;
            end else begin
              // next page of a split write
              pr_polls = '0;
              enter_state(ST_WSTART);
            end
          end
        end
        ST_RECV: begin
          if (ph == PH_SCL_LOW) begin
            pr_scl = 1'b0;
            if (pr_bit == 4'd0) pr_shift = '0;
          end else if (ph == PH_SDA_SET) begin
            // release for data bits, ACK all but the last byte
            pr_sda = (pr_bit < ACK_BIT) || (pr_left <= 16'd1);
          end else if (ph == PH_SCL_HIGH) begin
            pr_scl = 1'b1;
            if (pr_bit < ACK_BIT) pr_shift = {pr_shift[6:0], sda_in};
          end else if (pr_bit < ACK_BIT) begin
            pr_bit = pr_bit + 4'd1;
          end else begin
            rv      = 1'b1;
            rb      = pr_shift;
            pr_addr = pr_addr + 15'd1;
            pr_left = pr_left - 16'd1;
            enter_state((pr_left == 16'd0) ? ST_STOP : ST_RECV);
          end
        end
        default: begin
          if (ph == PH_SCL_LOW) begin
            pr_scl = 1'b0;
            if (pr_bit == 4'd0) begin
              case (pr_state)
                ST_WSEL: pr_shift = {cfg_dev_sel, 1'b0};
                ST_AHI:  pr_shift = {1'b0, pr_addr[14:8]};
                ST_ALO:  pr_shift = pr_addr[7:0];
                ST_DATA: pr_shift = wd;
                default: pr_shift = {cfg_dev_sel, 1'b1};
              endcase
            end
          end else if (ph == PH_SDA_SET) begin
            pr_sda = (pr_bit < ACK_BIT) ? pr_shift[7 - int'(pr_bit)] : 1'b1;
          end else if (ph == PH_SCL_HIGH) begin
            pr_scl = 1'b1;
            if (pr_bit >= ACK_BIT) pr_ack = sda_in;
          end else if (pr_bit < ACK_BIT) begin
            pr_bit = pr_bit + 4'd1;
          end else begin
            // acknowledge bit done: decide where to go
            case (pr_state)
              ST_WSEL: begin
                if (!pr_ack) begin
                  enter_state(ST_AHI);
                end else begin
                  pr_polls = pr_polls + 16'd1;
                  if (pr_polls >= cfg_poll_limit) abort_transfer(ERR_BUSY);
                  else enter_state(ST_WSTART);
                end
              end
              ST_AHI: begin
                if (pr_ack) abort_transfer(ERR_ADDR_HI);
                else enter_state(ST_ALO);
              end
              ST_ALO: begin
                if (pr_ack) begin
                  abort_transfer(ERR_ADDR_LO);
                end else if (pr_is_read) begin
                  enter_state(ST_RSTART);
                end else begin
                  enter_state(ST_DATA);
                  req = 1'b1;
                end
              end
              ST_DATA: begin
                if (pr_ack) begin
                  abort_transfer(ERR_DATA);
                end else begin
                  pr_addr = pr_addr + 15'd1;
                  pr_left = pr_left - 16'd1;
                  if (pr_left == 16'd0 || (pr_addr % PAGE_BYTES) == 0) begin
                    enter_state(ST_STOP);
                  end else begin
                    enter_state(ST_DATA);
                    req = 1'b1;
                  end
                end
              end
              default: begin
                if (pr_ack) abort_transfer(ERR_READ_SEL);
                else enter_state(ST_RECV);
              end
            endcase
          end
        end
      endcase
    end
    r.scl_level    = pr_scl;
    r.sda_level    = pr_sda;
    r.byte_request = req;
    r.read_byte    = rb;
    r.read_valid   = rv;
    r.busy_res     = (pr_state != ST_IDLE);
    r.done_res     = done;
    r.error_code   = pr_err;
  endtask

  // --------------------------------------------------------------------------
  // EEPROM responder: pick the data line level for the coming tick. Only
  // acknowledge slots are steered; every other tick gets a random level, which
  // also serves as read data.
  // --------------------------------------------------------------------------
  function automatic logic device_sda();
    logic ack_slot;
    ack_slot = (pr_phase == PH_SCL_HIGH) && (pr_bit >= ACK_BIT) &&
               (pr_state == ST_WSEL || pr_state == ST_AHI || pr_state == ST_ALO ||
                pr_state == ST_DATA || pr_state == ST_RSEL);
    if (!ack_slot) return 1'($urandom);
    if (pr_state == fault_state) return 1'b1;
    if (pr_state == ST_WSEL) return ($urandom_range(99) < wsel_nack_pct);
    return ($urandom_range(99) < noise_pct);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus plumbing
  // --------------------------------------------------------------------------
  // Offer one word, wait for it to be taken, then log what it must produce
  task automatic send_word(mode_e m, logic [14:0] a, logic [15:0] len,
                           logic [7:0] wd, logic sda);
    res_t want;
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata  <= {sda, wd, len, a};
    s_tuser  <= m;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    step_bus_master(m, a, len, wd, sda, want);
    expected_words.push_back(want);
    words_sent++;
  endtask

  // One request from idle to done: a few ignored idle words, the begin word,
  // then ticks until the model is idle again. Modes on busy ticks are random,
  // so begins while busy and the spare mode come along.
  task automatic run_transfer(mode_e m, logic [14:0] a, logic [15:0] len,
                              ctl_state_e fault);
    fault_state = fault;
    repeat ($urandom_range(2)) begin
      send_word(($urandom_range(1) != 0) ? MODE_SPARE : MODE_TICK,
                15'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    end
    send_word(m, a, len, 8'($urandom), 1'($urandom));
    while (pr_state != ST_IDLE) begin
      send_word(mode_e'($urandom_range(3)), 15'($urandom), 16'($urandom),
                8'($urandom), device_sda());
    end
    fault_state = ST_IDLE;
  endtask

  // Drop valid and hold until every owed word has come back
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers; only called with the block idle and drained
  task automatic configure(logic [15:0] poll, logic [6:0] dev);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_POLL_LIMIT;
    cfg_data  <= poll;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_poll_limit = poll;
    cfg_index <= CFG_DEV_SEL;
    cfg_data  <= {9'd0, dev};
    do @(posedge clk_i); while (!cfg_ready);
    cfg_dev_sel = dev;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] word %0d: %s", $time, words_checked, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare every accepted output word with the oldest owed word
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[10:3], m_tdata[11],
             m_tdata[12], m_tlast, m_tdata[15:13]};
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("output word %h with nothing owed", got));
      end else begin
        want = expected_words.pop_front();
        if (got.scl_level !== want.scl_level)
          report_mismatch($sformatf("scl_level %b, model %b", got.scl_level, want.scl_level));
        if (got.sda_level !== want.sda_level)
          report_mismatch($sformatf("sda_level %b, model %b", got.sda_level, want.sda_level));
        if (got.byte_request !== want.byte_request)
          report_mismatch($sformatf("byte_request %b, model %b",
                                    got.byte_request, want.byte_request));
        if (got.read_byte !== want.read_byte)
          report_mismatch($sformatf("read_byte %h, model %h", got.read_byte, want.read_byte));
        if (got.read_valid !== want.read_valid)
          report_mismatch($sformatf("read_valid %b, model %b", got.read_valid, want.read_valid));
        if (got.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, model %b", got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, model %b", got.done_res, want.done_res));
        if (got.error_code !== want.error_code)
          report_mismatch($sformatf("error_code %0d, model %0d", got.error_code, want.error_code));
      end
      words_checked++;
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Idle words with extreme fields, plain and spare mode: nothing may move
  task automatic test_idle_words();
    send_word(MODE_TICK, '0, '0, '0, 1'b0);
    send_word(MODE_SPARE, '1, '1, '1, 1'b1);
    send_word(MODE_SPARE, '0, '0, '0, 1'b0);
    send_word(MODE_TICK, '1, '1, '1, 1'b1);
  endtask

  // Zero length ends on the begin word, with no bus activity
  task automatic test_zero_length();
    run_transfer(MODE_WRITE, 15'h7FFF, 16'd0, ST_IDLE);
    run_transfer(MODE_READ, 15'h0000, 16'd0, ST_IDLE);
  endtask

  // Split at a page boundary while wrapping past the top of memory
  task automatic test_page_split_write();
    run_transfer(MODE_WRITE, 15'h7FFF, 16'd2, ST_IDLE);
  endtask

  // Device busy with a zero limit (acts as a single attempt) and the lowest
  // device address; then a refused data byte cuts the largest length short
  task automatic test_missing_acks();
    configure(16'd0, 7'd0);
    run_transfer(MODE_WRITE, 15'($urandom), 16'd1, ST_WSEL);
    configure(16'hFFFF, DEV_SEL_RST);
    run_transfer(MODE_WRITE, 15'h0010, 16'hFFFF, ST_DATA);
  endtask

  // Mostly well-formed transfers with random content; some zero lengths,
  // some broken by a refusal, some huge lengths cut short the same way
  task automatic test_random_traffic(int tx_pct, int rx_pct, logic [15:0] poll,
                                     logic [6:0] dev, int wsel_pct);
    int          phase_start;
    int          sel;
    logic        is_write;
    logic [14:0] a;
    logic [15:0] len;
    ctl_state_e  fault;
    configure(poll, dev);
    tx_gap_pct    = tx_pct;
    rx_stall_pct  = rx_pct;
    wsel_nack_pct = wsel_pct;
    noise_pct     = 3;
    phase_start   = words_sent;
    while (words_sent - phase_start < PHASE_WORDS) begin
      is_write = 1'($urandom);
      sel      = $urandom_range(99);
      a        = 15'($urandom);
      if ($urandom_range(1) != 0) a[5:0] = 6'd63 - 6'($urandom_range(2));
      len   = 16'($urandom_range(3, 1));
      fault = ST_IDLE;
      if (sel < 4) begin
        len = 16'd0;
      end else if (sel < 22) begin
        if (sel < 12) len = 16'($urandom);
        case ($urandom_range(2))
          0:       fault = ST_AHI;
          1:       fault = ST_ALO;
          default: fault = is_write ? ST_DATA : ST_RSEL;
        endcase
      end else if (sel < 30) begin
        len = 16'($urandom_range(8, 4));
      end
      run_transfer(is_write ? MODE_WRITE : MODE_READ, a, len, fault);
    end
  endtask

  // Stall the result side for a long stretch while a two-byte read (ACK then
  // NACK) keeps coming, so the block fills up and blocks its input; then
  // pause the sender until drained and restart from empty
  task automatic test_backpressure();
    tx_gap_pct    = 0;
    rx_stall_pct  = 0;
    noise_pct     = 0;
    hold_off_left = HOLD_OFF_CYCLES;
    run_transfer(MODE_READ, 15'($urandom), 16'd2, ST_IDLE);
    wait_for_drain();
    run_transfer(MODE_WRITE, 15'h7FFE, 16'd0, ST_IDLE);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // Model at reset values
    pr_state       = ST_IDLE;
    pr_phase       = '0;
    pr_bit         = '0;
    pr_shift       = '0;
    pr_addr        = '0;
    pr_left        = '0;
    pr_polls       = '0;
    pr_is_read     = 1'b0;
    pr_err         = ERR_NONE;
    pr_scl         = 1'b1;
    pr_sda         = 1'b1;
    pr_ack         = 1'b0;
    cfg_poll_limit = POLL_LIMIT_RST;
    cfg_dev_sel    = DEV_SEL_RST;

    // Hold reset low, then release it on a rising edge
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, sender idling lightly, receiver heavily
    tx_gap_pct    = 15;
    rx_stall_pct  = 71;
    wsel_nack_pct = 20;
    noise_pct     = 0;
    test_idle_words();
    test_zero_length();
    test_page_split_write();
    test_missing_acks();

    // Random part: swap idling sides, then none
    test_random_traffic(71, 15, 16'd1, 7'h7F, 10);
    test_random_traffic(0, 0, 16'd2, 7'($urandom), 20);
    test_backpressure();

    // Drain and let the pipeline settle
    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/i2cep_pkg.sv
sv/i2cep_cfg.sv
sv/i2cep_step.sv
sv/i2c_eeprom_page_controller_unit.sv
dv/i2c_eeprom_page_controller_unit_tb.sv
